/* hdl/mm4_pkg.sv */
// ---------------------------------------------------------------------------
// mm4_pkg: shared types and constants for the matrix multiply unit
// opcodes, sequencer states and default parameter values
// ---------------------------------------------------------------------------
package mm4_pkg;

  localparam int DIM_DEF       = 4;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_EMIT      = 16;

  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 4;
  localparam int VALUE_W  = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD_LEFT  = 2'd0,
    OP_LOAD_RIGHT = 2'd1,
    OP_MULTIPLY   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_WAIT,
    ST_EMIT
  } state_t;

endpackage

/* hdl/mm4_ram.sv */
// ---------------------------------------------------------------------------
// mm4_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ---------------------------------------------------------------------------
module mm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/matrix4x4_multiply_unit.sv */
// ---------------------------------------------------------------------------
// matrix4x4_multiply_unit: fixed-point square matrix multiply
// loads two column-major matrices, then emits every product entry in order
// ---------------------------------------------------------------------------
// loads (opcode 0 and 1) and ignored opcodes are accepted only in the idle state
// a multiply walks each entry in DIM steps through the single
//   shared 32x32 multiplier (ram read, product and accumulator registers), then an emit
// synchronous active-low reset clears both matrices (per-entry valid bits)
//   and the sequencer; no clearing pass, the block is ready right away
module matrix4x4_multiply_unit #(
  parameter int DIM       = mm4_pkg::DIM_DEF,
  parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mm4_pkg::OPCODE_W-1:0]    in_opcode,
  input  logic [mm4_pkg::INDEX_W-1:0]     in_element_index,
  input  logic signed [mm4_pkg::VALUE_W-1:0] in_element_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mm4_pkg::INDEX_W-1:0]     out_product_index,
  output logic signed [mm4_pkg::VALUE_W-1:0] out_product_value,
  output logic                            out_saturated,
  output logic                            out_last_entry
);

  localparam int NENT  = DIM * DIM;
  localparam int AW    = $clog2(NENT);
  localparam int CW    = $clog2(DIM);
  localparam int NEMIT = (NENT > mm4_pkg::MAX_EMIT) ? mm4_pkg::MAX_EMIT : NENT;
  localparam int VW    = mm4_pkg::VALUE_W;
  localparam int PW    = 2 * VW;
  // sum of DIM full products needs CW extra bits
  localparam int ACC_W = PW + CW;
  localparam int IW    = mm4_pkg::INDEX_W;

  localparam logic [IW-1:0] K_LAST  = IW'(NEMIT - 1);
  localparam logic [CW-1:0] I_LAST  = CW'(DIM - 1);
  localparam logic [AW-1:0] DIM_A   = AW'(DIM);
  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

  // ---- state ----
  mm4_pkg::state_t state_r, state_nxt;

  logic [IW-1:0] k_r, k_nxt;          // entry being computed
  logic [CW-1:0] row_r, row_nxt;      // row of that entry
  logic [CW-1:0] i_r, i_nxt;          // dot product step
  logic [AW-1:0] rbase_r, rbase_nxt;  // col * DIM
  logic [AW-1:0] laddr_r, laddr_nxt;  // left read address row + i*DIM
  logic [AW-1:0] raddr_r, raddr_nxt;  // right read address i + col*DIM

  logic [NENT-1:0] lvld_r, rvld_r;    // entry written since reset
  logic            lv_q_r, rv_q_r;

  logic            rd_vld_r, rd_last_r;
  logic            mul_vld_r, mul_last_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r;

  logic            out_valid_r;
  logic [IW-1:0]   out_index_r;
  logic signed [VW-1:0] out_value_r;
  logic            out_sat_r, out_last_r;

  // ---- control strobes from the sequencer ----
  logic in_fire, start, issue, acc_clr, emit_load, out_free;
  logic load_we_l, load_we_r, idx_ok;
  logic [AW-1:0] waddr;
  logic [VW-1:0] lq, rq;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign start    = in_fire && (in_opcode == mm4_pkg::OP_MULTIPLY);

  // loads outside the matrix are dropped
  assign idx_ok    = 32'(in_element_index) < NENT;
  assign waddr     = AW'(in_element_index);
  assign load_we_l = in_fire && idx_ok && (in_opcode == mm4_pkg::OP_LOAD_LEFT);
  assign load_we_r = in_fire && idx_ok && (in_opcode == mm4_pkg::OP_LOAD_RIGHT);

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mm4_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = mm4_pkg::ST_MAC;
        end
      end
      mm4_pkg::ST_MAC: begin
        if (i_r == I_LAST) begin
          state_nxt = mm4_pkg::ST_WAIT;
        end
      end
      mm4_pkg::ST_WAIT: begin
        // last product lands in the accumulator at this edge
        if (mul_vld_r && mul_last_r) begin
          state_nxt = mm4_pkg::ST_EMIT;
        end
      end
      mm4_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = (k_r == K_LAST) ? mm4_pkg::ST_IDLE : mm4_pkg::ST_MAC;
        end
      end
      default: state_nxt = mm4_pkg::ST_IDLE;
    endcase
  end

  // ---- sequencer outputs ----
  always_comb begin
    in_ready  = 1'b0;
    issue     = 1'b0;
    emit_load = 1'b0;
    unique case (state_r)
      mm4_pkg::ST_IDLE: in_ready  = 1'b1;
      mm4_pkg::ST_MAC:  issue     = 1'b1;
      mm4_pkg::ST_WAIT: ;
      mm4_pkg::ST_EMIT: emit_load = out_free;
      default: ;
    endcase
  end

  assign acc_clr = issue && (i_r == '0);

  // ---- address walk ----
  always_comb begin
    k_nxt     = k_r;
    row_nxt   = row_r;
    i_nxt     = i_r;
    rbase_nxt = rbase_r;
    laddr_nxt = laddr_r;
    raddr_nxt = raddr_r;
    priority if (start) begin
      k_nxt     = '0;
      row_nxt   = '0;
      i_nxt     = '0;
      rbase_nxt = '0;
      laddr_nxt = '0;
      raddr_nxt = '0;
    end else if (issue) begin
      i_nxt     = (i_r == I_LAST) ? '0 : i_r + 1'b1;
      laddr_nxt = laddr_r + DIM_A;
      raddr_nxt = raddr_r + 1'b1;
    end else if (emit_load && (k_r != K_LAST)) begin
      k_nxt = k_r + 1'b1;
      if (row_r == I_LAST) begin
        // step to the top of the next column
        row_nxt   = '0;
        rbase_nxt = rbase_r + DIM_A;
        laddr_nxt = '0;
        raddr_nxt = rbase_r + DIM_A;
      end else begin
        row_nxt   = row_r + 1'b1;
        laddr_nxt = AW'(row_r + 1'b1);
        raddr_nxt = rbase_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mm4_pkg::ST_IDLE;
      k_r     <= '0;
      row_r   <= '0;
      i_r     <= '0;
      rbase_r <= '0;
      laddr_r <= '0;
      raddr_r <= '0;
      lvld_r  <= '0;
      rvld_r  <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      row_r   <= row_nxt;
      i_r     <= i_nxt;
      rbase_r <= rbase_nxt;
      laddr_r <= laddr_nxt;
      raddr_r <= raddr_nxt;
      if (load_we_l) begin
        lvld_r[waddr] <= 1'b1;
      end
      if (load_we_r) begin
        rvld_r[waddr] <= 1'b1;
      end
    end
  end

  // ---- matrix stores ----
  mm4_ram #(.WIDTH(VW), .DEPTH(NENT)) u_left_ram (
    .clk   (clk),
    .we    (load_we_l),
    .waddr (waddr),
    .wdata (in_element_value),
    .raddr (laddr_r),
    .rdata (lq)
  );

  mm4_ram #(.WIDTH(VW), .DEPTH(NENT)) u_right_ram (
    .clk   (clk),
    .we    (load_we_r),
    .waddr (waddr),
    .wdata (in_element_value),
    .raddr (raddr_r),
    .rdata (rq)
  );

  // ---- multiply-accumulate pipeline: read, multiply, accumulate ----
  logic signed [VW-1:0] opl, opr;
  // unwritten entries read as zero
  assign opl = lv_q_r ? $signed(lq) : '0;
  assign opr = rv_q_r ? $signed(rq) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      rd_last_r  <= 1'b0;
      mul_vld_r  <= 1'b0;
      mul_last_r <= 1'b0;
    end else begin
      rd_vld_r   <= issue;
      rd_last_r  <= issue && (i_r == I_LAST);
      mul_vld_r  <= rd_vld_r;
      mul_last_r <= rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    lv_q_r <= lvld_r[laddr_r];
    rv_q_r <= rvld_r[raddr_r];
    prod_r <= opl * opr;
    if (acc_clr) begin
      acc_r <= '0;
    end else if (mul_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // ---- scale back and clip ----
  logic signed [ACC_W-1:0] sh;
  logic [ACC_W-VW:0]       upper;
  logic                    fits;
  logic signed [VW-1:0]    clip_val;

  assign sh    = acc_r >>> FRAC_BITS;
  assign upper = sh[ACC_W-1:VW-1];
  assign fits  = (&upper) || !(|upper);

  always_comb begin
    priority if (fits) begin
      clip_val = sh[VW-1:0];
    end else if (sh[ACC_W-1]) begin
      clip_val = VAL_MIN;
    end else begin
      clip_val = VAL_MAX;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_index_r <= k_r;
      out_value_r <= clip_val;
      out_sat_r   <= !fits;
      out_last_r  <= (k_r == K_LAST);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_product_index = out_index_r;
  assign out_product_value = out_value_r;
  assign out_saturated     = out_sat_r;
  assign out_last_entry    = out_last_r;

  // ---- checks ----
  a_prod_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
    mul_vld_r |-> (state_r == mm4_pkg::ST_MAC || state_r == mm4_pkg::ST_WAIT))
    else $error("product outside multiply phase");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_entry == (out_product_index == K_LAST)))
    else $error("last flag does not match entry index");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_product_value == VAL_MAX || out_product_value == VAL_MIN))
    else $error("saturated entry not at a range limit");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == mm4_pkg::OP_MULTIPLY) |=>
      (state_r == mm4_pkg::ST_MAC && k_r == '0 && i_r == '0))
    else $error("multiply did not start at first entry");

endmodule

/* tb/sv/matrix4x4_multiply_unit_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// matrix4x4_multiply_unit_test: self-checking bench for the matrix multiply
// loads both matrices, runs multiplies and checks every product transaction
// against a bit-accurate Q16.16 predictor under random idling and stalls
// ---------------------------------------------------------------------------
module matrix4x4_multiply_unit_test;

  // block geometry, taken from the defaults the instance is built with
  localparam int DIM    = mm4_pkg::DIM_DEF;
  localparam int FRAC   = mm4_pkg::FRAC_BITS_DEF;
  localparam int N_ENT  = DIM * DIM;
  localparam int N_EMIT = (N_ENT > mm4_pkg::MAX_EMIT) ? mm4_pkg::MAX_EMIT : N_ENT;
  localparam int ACC_W  = 2 * mm4_pkg::VALUE_W + 8;

  // the one opcode value the package leaves undefined; the block must ignore it
  localparam logic [mm4_pkg::OPCODE_W-1:0] OP_RESERVED = 2'd3;

  // fixed-point corner values
  localparam logic [mm4_pkg::VALUE_W-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [mm4_pkg::VALUE_W-1:0] Q_HALF    = 32'h0000_8000;
  localparam logic [mm4_pkg::VALUE_W-1:0] V_MAX     = 32'h7FFF_FFFF;
  localparam logic [mm4_pkg::VALUE_W-1:0] V_MIN     = 32'h8000_0000;
  localparam logic [mm4_pkg::VALUE_W-1:0] V_NEG_LSB = 32'hFFFF_FFFF;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 8;
  localparam int IDLE_PCT      = 28;
  localparam int HOLD_CYCLES   = 400;
  // one full multiply plus margin: anything arriving after this is stray
  localparam int SETTLE_CYCLES = mm4_pkg::MAX_EMIT * (DIM + 3) + 20;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [mm4_pkg::INDEX_W-1:0] index;
    logic [mm4_pkg::VALUE_W-1:0] value;
    logic                        sat;
    logic                        last;
  } product_entry_t;

  // dut ports, all inputs known from time zero
  logic                         clk              = 1'b0;
  logic                         rst_n            = 1'b0;
  logic                         in_valid         = 1'b0;
  logic [mm4_pkg::OPCODE_W-1:0] in_opcode        = mm4_pkg::OP_LOAD_LEFT;
  logic [mm4_pkg::INDEX_W-1:0]  in_element_index = '0;
  logic [mm4_pkg::VALUE_W-1:0]  in_element_value = '0;
  logic                         out_ready        = 1'b0;
  logic                         in_ready;
  logic                         out_valid;
  logic [mm4_pkg::INDEX_W-1:0]  out_product_index;
  logic [mm4_pkg::VALUE_W-1:0]  out_product_value;
  logic                         out_saturated;
  logic                         out_last_entry;

  // predictor state: shadow copies of both matrices
  logic signed [mm4_pkg::VALUE_W-1:0] left_mat  [N_ENT];
  logic signed [mm4_pkg::VALUE_W-1:0] right_mat [N_ENT];
  product_entry_t                     pending_products [$];

  int n_errors    = 0;
  int cycle_count = 0;
  int idle_pct    = IDLE_PCT;

  // long receiver hold: tests bump hold_req, the receiver process counts it out
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  matrix4x4_multiply_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_element_index  (in_element_index),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_product_index (out_product_index),
    .out_product_value (out_product_value),
    .out_saturated     (out_saturated),
    .out_last_entry    (out_last_entry)
  );

  always #CLK_HALF clk = ~clk;

  // run limit, generous against the slowest legal run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  // one entry of the product: exact dot product, arithmetic shift, saturate
  function automatic product_entry_t compute_entry(int k);
    logic signed [ACC_W-1:0] lhs;
    logic signed [ACC_W-1:0] rhs;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] scaled;
    product_entry_t          e;
    int                      row;
    int                      col;
    row = k % DIM;
    col = k / DIM;
    acc = '0;
    for (int i = 0; i < DIM; i++) begin
      // sign extension to the accumulator width keeps every product exact
      lhs = ACC_W'(left_mat[row + i * DIM]);
      rhs = ACC_W'(right_mat[i + col * DIM]);
      acc = acc + lhs * rhs;
    end
    // shift floors toward minus infinity, not toward zero
    scaled  = acc >>> FRAC;
    e.index = mm4_pkg::INDEX_W'(k);
    e.last  = (k == N_EMIT - 1);
    if (scaled > SAT_HI) begin
      e.value = V_MAX;
      e.sat   = 1'b1;
    end else if (scaled < SAT_LO) begin
      e.value = V_MIN;
      e.sat   = 1'b1;
    end else begin
      e.value = scaled[mm4_pkg::VALUE_W-1:0];
      e.sat   = 1'b0;
    end
    return e;
  endfunction

  // update the shadow matrices, or queue all entries a multiply will emit
  function automatic void predict_transaction(logic [mm4_pkg::OPCODE_W-1:0] op,
                                              logic [mm4_pkg::INDEX_W-1:0] idx,
                                              logic [mm4_pkg::VALUE_W-1:0] val);
    case (op)
      mm4_pkg::OP_LOAD_LEFT: begin
        if (idx < N_ENT) left_mat[idx] = val;
      end
      mm4_pkg::OP_LOAD_RIGHT: begin
        if (idx < N_ENT) right_mat[idx] = val;
      end
      mm4_pkg::OP_MULTIPLY: begin
        // index and value fields are don't-care here
        for (int k = 0; k < N_EMIT; k++) pending_products.push_back(compute_entry(k));
      end
      default: begin
        // reserved opcode: no state change, nothing emitted
      end
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // input side
  // ------------------------------------------------------------------------

  // offer one transaction, optionally after a short gap, and hold until taken
  task automatic send_item(input logic [mm4_pkg::OPCODE_W-1:0] op,
                           input logic [mm4_pkg::INDEX_W-1:0] idx,
                           input logic [mm4_pkg::VALUE_W-1:0] val);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_element_index <= idx;
    in_element_value <= val;
    // in_ready read right after the edge is the value the edge saw
    do @(posedge clk); while (!in_ready);
    predict_transaction(op, idx, val);
  endtask

  // drop valid and wait for every queued product to come out
  task automatic wait_for_products();
    in_valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
  endtask

  // mix of plain Q16.16 magnitudes, full-range noise and corners
  function automatic logic [mm4_pkg::VALUE_W-1:0] pick_element();
    case ($urandom_range(5))
      0, 1: return $urandom();
      2: return $urandom_range(32'h0003_FFFF) - 32'h0002_0000;
      3: begin
        if ($urandom_range(1) != 0) return $urandom() & 32'h00FF_FFFF;
        else return -($urandom() & 32'h00FF_FFFF);
      end
      default: begin
        case ($urandom_range(4))
          0: return V_MAX;
          1: return V_MIN;
          2: return V_NEG_LSB;
          3: return Q_ONE;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // mostly load bursts closed by a multiply, some stray loads and noise;
  // reserved-opcode transactions are ignored by the block and not counted
  task automatic run_random_traffic(input int n_items);
    int                           sent;
    int                           n_loads;
    int                           kind;
    logic [mm4_pkg::OPCODE_W-1:0] side;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        // scattered loads (possibly none) then multiply
        n_loads = $urandom_range(0, 10);
        for (int k = 0; k < n_loads; k++) begin
          side = ($urandom_range(1) != 0) ? mm4_pkg::OP_LOAD_RIGHT : mm4_pkg::OP_LOAD_LEFT;
          send_item(side, mm4_pkg::INDEX_W'($urandom()), pick_element());
        end
        send_item(mm4_pkg::OP_MULTIPLY, mm4_pkg::INDEX_W'($urandom()), $urandom());
        sent += n_loads + 1;
      end else if (kind < 88) begin
        // full column-major sweep of one matrix then multiply
        side = ($urandom_range(1) != 0) ? mm4_pkg::OP_LOAD_RIGHT : mm4_pkg::OP_LOAD_LEFT;
        for (int k = 0; k < N_ENT; k++) begin
          send_item(side, mm4_pkg::INDEX_W'(k), pick_element());
        end
        send_item(mm4_pkg::OP_MULTIPLY, mm4_pkg::INDEX_W'($urandom()), $urandom());
        sent += N_ENT + 1;
      end else if (kind < 94) begin
        side = ($urandom_range(1) != 0) ? mm4_pkg::OP_LOAD_RIGHT : mm4_pkg::OP_LOAD_LEFT;
        send_item(side, mm4_pkg::INDEX_W'($urandom()), pick_element());
        sent++;
      end else begin
        send_item(OP_RESERVED, mm4_pkg::INDEX_W'($urandom()), $urandom());
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // output side: compare each product transaction, then pick next ready
  // ------------------------------------------------------------------------

  task automatic check_product();
    product_entry_t want;
    if (pending_products.size() == 0) begin
      $error("unexpected product transaction: index %0d value %0d",
             out_product_index, $signed(out_product_value));
      n_errors++;
      return;
    end
    want = pending_products.pop_front();
    if (out_product_index !== want.index) begin
      $error("product_index: expected %0d, actual %0d", want.index, out_product_index);
      n_errors++;
    end
    if (out_product_value !== want.value) begin
      $error("product_value: expected %0d, actual %0d",
             $signed(want.value), $signed(out_product_value));
      n_errors++;
    end
    if (out_saturated !== want.sat) begin
      $error("saturated: expected %0d, actual %0d", want.sat, out_saturated);
      n_errors++;
    end
    if (out_last_entry !== want.last) begin
      $error("last_entry: expected %0d, actual %0d", want.last, out_last_entry);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_product();
    // a new hold request restarts the long stall
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // both matrices come out of reset as zero
  task automatic test_reset_contents();
    send_item(mm4_pkg::OP_MULTIPLY, '0, '0);
  endtask

  // full-scale elements against a near-identity right matrix; the half on
  // the diagonal times minus one lsb shows floor rather than round-to-zero
  task automatic test_extreme_elements();
    send_item(mm4_pkg::OP_LOAD_RIGHT, 4'd0, Q_ONE);
    send_item(mm4_pkg::OP_LOAD_RIGHT, 4'd5, Q_ONE);
    send_item(mm4_pkg::OP_LOAD_RIGHT, 4'd10, Q_HALF);
    send_item(mm4_pkg::OP_LOAD_RIGHT, 4'd15, Q_ONE);
    send_item(mm4_pkg::OP_LOAD_LEFT, 4'd0, V_MAX);
    send_item(mm4_pkg::OP_LOAD_LEFT, 4'd15, V_MIN);
    send_item(mm4_pkg::OP_LOAD_LEFT, 4'd5, 32'h0000_0003);
    send_item(mm4_pkg::OP_LOAD_LEFT, 4'd10, V_NEG_LSB);
    send_item(mm4_pkg::OP_MULTIPLY, '0, '0);
  endtask

  // clip at both ends, one unclipped neighbor; multiply fields left nonzero
  task automatic test_saturation();
    send_item(mm4_pkg::OP_LOAD_RIGHT, 4'd0, V_MAX);
    send_item(mm4_pkg::OP_LOAD_RIGHT, 4'd4, V_MIN);
    send_item(mm4_pkg::OP_LOAD_RIGHT, 4'd12, 32'h0000_0001);
    send_item(mm4_pkg::OP_MULTIPLY, 4'd15, V_NEG_LSB);
  endtask

  // reserved opcode must neither load nor multiply
  task automatic test_reserved_opcode();
    send_item(OP_RESERVED, 4'd0, 32'h1234_5678);
    send_item(mm4_pkg::OP_MULTIPLY, '0, '0);
  endtask

  task automatic test_random_traffic();
    idle_pct = IDLE_PCT;
    run_random_traffic(220);
  endtask

  // back-to-back on both sides, no idling at all
  task automatic test_steady_stream();
    idle_pct = 0;
    run_random_traffic(120);
    idle_pct = IDLE_PCT;
  endtask

  // receiver stalls for a long stretch while the sender keeps offering,
  // so the unit backs up and drops in_ready
  task automatic test_output_backpressure();
    idle_pct = IDLE_PCT;
    hold_req++;
    send_item(mm4_pkg::OP_MULTIPLY, '0, '0);
    run_random_traffic(60);
  endtask

  // sender goes quiet until the output side has fully drained
  task automatic test_drain_pause();
    for (int r = 0; r < 4; r++) begin
      run_random_traffic(15);
      wait_for_products();
    end
  endtask

  initial begin
    for (int i = 0; i < N_ENT; i++) begin
      left_mat[i]  = '0;
      right_mat[i] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_contents();
    test_extreme_elements();
    test_saturation();
    test_reserved_opcode();
    test_random_traffic();
    test_steady_stream();
    test_output_backpressure();
    test_drain_pause();

    wait_for_products();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
